[sv/assert_macros.svh]
// Assertion macros shared by the depth map decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define DMSD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DMSD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/dmsd_pkg.sv]
// Types and constants shared by the depth map stream decoder.
`default_nettype none
package dmsd_pkg;

	localparam int MAX_DIM_DEF = 4096;

	localparam int HDR_POS_W = 5;
	localparam logic [HDR_POS_W-1:0] HDR_BYTES = 5'd24;
	localparam logic [HDR_POS_W-1:0] MAGIC_END = 5'd8;
	localparam logic [HDR_POS_W-1:0] WIDTH_END = 5'd16;
	localparam logic [63:0] MAGIC_WORD = 64'h4445_5054_484D_4150;

	typedef enum logic {
		KIND_PIXEL  = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_DIM      = 3'd4
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] depth;
		logic [11:0] row;
		logic [11:0] col;
		status_t     status;
		logic        last;
	} result_t;

	// Up to two results caused by one byte, in order.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    first;
		result_t    second;
	} result_pair_t;

endpackage
`default_nettype wire

[sv/dmsd_parse.sv]
// Header parse, pixel assembly and final status for one payload byte per step.
`default_nettype none
module dmsd_parse
	import dmsd_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   data_byte,
	input  wire logic         end_of_data,
	output result_pair_t      pair
);

	localparam int DimW = $clog2(MAX_DIM + 1);

	logic [HDR_POS_W-1:0] hpos_q, hpos_d, hpos_inc;
	logic [63:0]          shift_q, shift_d, shift_inc;
	logic [DimW-1:0]      width_q, width_d;
	logic [DimW-1:0]      height_q, height_d;
	logic [DimW-1:0]      col_q, col_d;
	logic [DimW-1:0]      row_q, row_d;
	logic [7:0]           high_q, high_d;
	logic                 phase_q, phase_d;
	status_t              err_q, err_d;
	logic                 in_hdr, room, dim_big, pix_ok;
	status_t              fin_stat;
	result_t              pix_res, stat_res;

	assign in_hdr    = hpos_q < HDR_BYTES;
	assign hpos_inc  = hpos_q + 1'b1;
	assign shift_inc = {shift_q[55:0], data_byte};
	assign dim_big   = shift_inc > 64'(MAX_DIM);
	assign room      = (width_q != '0) && (row_q < height_q);

	// Next state for the byte in hand
	always_comb begin
		hpos_d   = hpos_q;
		shift_d  = shift_q;
		width_d  = width_q;
		height_d = height_q;
		col_d    = col_q;
		row_d    = row_q;
		high_d   = high_q;
		phase_d  = phase_q;
		err_d    = err_q;
		pix_ok   = 1'b0;
		if (in_hdr) begin
			hpos_d  = hpos_inc;
			shift_d = shift_inc;
			if (hpos_inc == MAGIC_END) begin
				if (shift_inc != MAGIC_WORD && err_q == ST_OK) err_d = ST_MAGIC;
			end else if (hpos_inc == WIDTH_END) begin
				if (dim_big) begin
					width_d = '0;
					if (err_q == ST_OK) err_d = ST_DIM;
				end else begin
					width_d = DimW'(shift_inc);
				end
			end else if (hpos_inc == HDR_BYTES) begin
				if (dim_big) begin
					height_d = '0;
					if (err_q == ST_OK) err_d = ST_DIM;
				end else begin
					height_d = DimW'(shift_inc);
				end
			end
		end else if (!room) begin
			// Excess data or empty map
			if (err_q == ST_OK) err_d = ST_MISMATCH;
		end else if (!phase_q) begin
			high_d  = data_byte;
			phase_d = 1'b1;
		end else begin
			phase_d = 1'b0;
			pix_ok  = (err_q == ST_OK);
			if ({1'b0, col_q} + 1'b1 >= {1'b0, width_q}) begin
				col_d = '0;
				row_d = row_q + 1'b1;
			end else begin
				col_d = col_q + 1'b1;
			end
		end
	end

	// Final status after this byte, short header first
	always_comb begin
		priority if (hpos_d < HDR_BYTES) fin_stat = ST_SHORT;
		else if (err_d != ST_OK) fin_stat = err_d;
		else if (phase_d || ((width_d != '0) && (row_d < height_d))) fin_stat = ST_MISMATCH;
		else fin_stat = ST_OK;
	end

	// Build the results for this byte
	always_comb begin
		pix_res.kind    = KIND_PIXEL;
		pix_res.depth   = {high_q, data_byte};
		pix_res.row     = 12'(row_q);
		pix_res.col     = 12'(col_q);
		pix_res.status  = ST_OK;
		pix_res.last    = !end_of_data;
		stat_res.kind   = KIND_STATUS;
		stat_res.depth  = '0;
		stat_res.row    = '0;
		stat_res.col    = '0;
		stat_res.status = fin_stat;
		stat_res.last   = 1'b1;
		if (pix_ok) begin
			pair.cnt    = end_of_data ? 2'd2 : 2'd1;
			pair.first  = pix_res;
			pair.second = stat_res;
		end else begin
			pair.cnt    = end_of_data ? 2'd1 : 2'd0;
			pair.first  = stat_res;
			pair.second = stat_res;
		end
	end

	// Advance state; clear everything after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q   <= '0;
			shift_q  <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			high_q   <= '0;
			phase_q  <= 1'b0;
			err_q    <= ST_OK;
		end else if (step) begin
			if (end_of_data) begin
				hpos_q   <= '0;
				shift_q  <= '0;
				width_q  <= '0;
				height_q <= '0;
				col_q    <= '0;
				row_q    <= '0;
				high_q   <= '0;
				phase_q  <= 1'b0;
				err_q    <= ST_OK;
			end else begin
				hpos_q   <= hpos_d;
				shift_q  <= shift_d;
				width_q  <= width_d;
				height_q <= height_d;
				col_q    <= col_d;
				row_q    <= row_d;
				high_q   <= high_d;
				phase_q  <= phase_d;
				err_q    <= err_d;
			end
		end
	end

endmodule
`default_nettype wire

[sv/depth_map_stream_decoder.sv]
// Top level of the depth map stream decoder: input stage, parser and result buffer.
//
//  channel  | direction | tdata                          | tuser       | tlast
//  s_axis   | in        | [7:0] data_byte                | -           | end_of_data
//  m_axis   | out       | depth, row, column, status     | result_kind | last
//
// One byte per cycle is taken unless the parser is held; a byte is registered in the input
// stage and parsed once the result buffer has room. A pixel is on m_axis once it is loaded
// into the result buffer. The final byte gives up to two results; while the two-entry
// result buffer holds two results, the input stage is held.
// Reset clears all parser state; a stalled m_axis holds the input stage.
`default_nettype none
module depth_map_stream_decoder
	import dmsd_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // [15:0] depth_value, [27:16] pixel_row,
	                                        // [39:28] pixel_column, [42:40] status, zero above
	output logic             m_axis_tuser,  // [0] result_kind
	output logic             m_axis_tlast
);

`include "assert_macros.svh"

	logic         in_valid_s1;
	logic [7:0]   in_byte_s1;
	logic         in_fin_s1;
	logic [1:0]   out_cnt_q;
	logic         out_head_q;
	result_t      slot_q [2];
	result_t      cur;
	result_pair_t pair;
	logic         out_take, buf_room, step;

	assign out_take      = m_axis_tvalid && m_axis_tready;
	assign buf_room      = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && out_take);
	assign step          = in_valid_s1 && buf_room;
	assign s_axis_tready = !in_valid_s1 || step;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_byte_s1 <= s_axis_tdata;
			in_fin_s1  <= s_axis_tlast;
		end
	end

	dmsd_parse #(
		.MAX_DIM(MAX_DIM)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (in_byte_s1),
		.end_of_data(in_fin_s1),
		.pair       (pair)
	);

	// Result buffer count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q  <= 2'd0;
			out_head_q <= 1'b0;
		end else if (step && pair.cnt != 2'd0) begin
			out_cnt_q  <= pair.cnt;
			out_head_q <= 1'b0;
		end else if (out_take) begin
			out_cnt_q  <= out_cnt_q - 2'd1;
			out_head_q <= !out_head_q;
		end
	end

	// Result buffer payload
	always_ff @(posedge clk) begin
		if (step && pair.cnt != 2'd0) begin
			slot_q[0] <= pair.first;
			slot_q[1] <= pair.second;
		end
	end

	assign cur           = slot_q[out_head_q];
	assign m_axis_tvalid = out_cnt_q != 2'd0;
	assign m_axis_tdata  = {5'd0, cur.status, cur.col, cur.row, cur.depth};
	assign m_axis_tuser  = cur.kind;
	assign m_axis_tlast  = cur.last;

	`DMSD_ASSERT_ALWAYS(a_cnt_range, out_cnt_q != 2'd3,
		"result buffer count out of range")
	`DMSD_ASSERT_IMPL(a_status_last, m_axis_tvalid && m_axis_tuser == KIND_STATUS,
		m_axis_tlast, "status item without tlast")
	`DMSD_ASSERT_IMPL(a_pixel_clean, m_axis_tvalid && m_axis_tuser == KIND_PIXEL,
		m_axis_tdata[42:40] == ST_OK, "pixel item with status set")
	`DMSD_ASSERT_NEXT(a_pair_load, step && pair.cnt == 2'd2,
		out_cnt_q == 2'd2 && out_head_q == 1'b0, "result pair not loaded")

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the depth map stream decoder: directed and random payloads.
module testbench;
	import dmsd_pkg::*;

	localparam int          MAX_SIDE  = 4096;
	localparam logic [63:0] MAP_MAGIC = 64'h4445_5054_484D_4150;
	localparam int          HDR_LEN   = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	depth_map_stream_decoder #(.MAX_DIM(MAX_SIDE)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state mirrored by the predictor
	logic [4:0]  hdr_count = '0;
	logic [63:0] hdr_word = '0;
	int unsigned map_w = 0;
	int unsigned map_h = 0;
	int unsigned col_idx = 0;
	int unsigned row_idx = 0;
	logic [7:0]  hi_byte = '0;
	bit          half = 1'b0;
	status_t     err = ST_OK;

	result_t awaited_results[$];

	bit idle_on = 1'b1;
	int fail_count = 0;
	int bytes_sent = 0;
	int maps_sent = 0;
	int pixels_seen = 0;
	int status_seen[0:4] = '{0, 0, 0, 0, 0};

	// Keep only the first error of a payload
	function automatic void flag_error(input status_t code);
		if (err == ST_OK)
			err = code;
	endfunction

	// Accept a header dimension, or drop it to zero when over the limit
	function automatic int unsigned clip_dim(input logic [63:0] v);
		if (v > 64'(MAX_SIDE)) begin
			flag_error(ST_DIM);
			return 0;
		end
		return v[31:0];
	endfunction

	function automatic int map_bytes(input int w, input int h);
		return HDR_LEN + 2 * w * h;
	endfunction

	// Advance the mirrored decoder by one byte and queue the results it owes
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		result_t r;
		status_t st;
		if (hdr_count < HDR_LEN) begin
			hdr_word = {hdr_word[55:0], b};
			hdr_count++;
			if (hdr_count == 5'd8) begin
				if (hdr_word != MAP_MAGIC)
					flag_error(ST_MAGIC);
			end else if (hdr_count == 5'd16) begin
				map_w = clip_dim(hdr_word);
			end else if (hdr_count == HDR_LEN) begin
				map_h = clip_dim(hdr_word);
			end
		end else if (map_w == 0 || row_idx >= map_h) begin
			flag_error(ST_MISMATCH);
		end else if (!half) begin
			hi_byte = b;
			half = 1'b1;
		end else begin
			half = 1'b0;
			if (err == ST_OK) begin
				r = '0;
				r.kind = KIND_PIXEL;
				r.depth = {hi_byte, b};
				r.row = row_idx[11:0];
				r.col = col_idx[11:0];
				r.last = !fin;
				awaited_results.insert(awaited_results.size(), r);
			end
			if (col_idx + 1 >= map_w) begin
				col_idx = 0;
				row_idx++;
			end else begin
				col_idx++;
			end
		end
		if (fin) begin
			if (hdr_count < HDR_LEN)
				st = ST_SHORT;
			else if (err != ST_OK)
				st = err;
			else if (half || (map_w != 0 && row_idx < map_h))
				st = ST_MISMATCH;
			else
				st = ST_OK;
			r = '0;
			r.kind = KIND_STATUS;
			r.status = st;
			r.last = 1'b1;
			awaited_results.insert(awaited_results.size(), r);
			// Start over for the next payload
			hdr_count = '0;
			hdr_word = '0;
			map_w = 0;
			map_h = 0;
			col_idx = 0;
			row_idx = 0;
			hi_byte = '0;
			half = 1'b0;
			err = ST_OK;
		end
	endtask

	// Offer one item on s_axis and hold it until accepted
	task automatic push_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		decode_byte(b, fin);
		bytes_sent++;
	endtask

	// Send a header followed by pixel bytes; total counts every byte, pix < 0 means random
	task automatic send_map(input logic [63:0] magic, input logic [63:0] w,
			input logic [63:0] h, input int total, input int pix);
		logic [191:0] hdr;
		logic [7:0] b;
		hdr = {magic, w, h};
		for (int i = 0; i < total; i++) begin
			if (i < HDR_LEN)
				b = hdr[191 - 8 * i -: 8];
			else if (pix < 0)
				b = $urandom_range(255);
			else
				b = pix[7:0];
			push_byte(b, i == total - 1);
		end
		maps_sent++;
	endtask

	// Mostly well-formed payloads, some with broken magic, dimensions or length
	task automatic random_map();
		logic [63:0] magic, w, h;
		int pick, exact, total;
		pick = $urandom_range(99);
		magic = (pick < 90) ? MAP_MAGIC : MAP_MAGIC ^ (64'd1 << $urandom_range(63));
		w = 64'($urandom_range(6));
		h = 64'($urandom_range(6));
		exact = map_bytes(int'(w), int'(h));
		pick = $urandom_range(99);
		if (pick < 3) begin
			w = {$urandom, $urandom} | 64'h1_0000;
			exact = HDR_LEN + $urandom_range(6);
		end else if (pick < 6) begin
			h = {$urandom, $urandom} | 64'h1_0000;
			exact = HDR_LEN + $urandom_range(6);
		end else if (pick < 8) begin
			w = 64'(MAX_SIDE);
			h = 64'd0;
			exact = HDR_LEN;
		end
		pick = $urandom_range(99);
		if (pick < 65)
			total = exact;
		else if (pick < 80)
			total = exact + $urandom_range(1, 3);
		else if (pick < 90)
			total = (exact > 3) ? exact - $urandom_range(1, 3) : 1;
		else
			total = $urandom_range(1, HDR_LEN);
		send_map(magic, w, h, total, -1);
	endtask

	task automatic test_header_edges();
		send_map(MAP_MAGIC, 2, 2, 1, -1);
		// too short outranks a bad magic word
		send_map(MAP_MAGIC ^ 64'd1, 2, 2, 8, -1);
		send_map(MAP_MAGIC, 2, 2, HDR_LEN - 1, -1);
		// zero-sized maps with only a header are fine
		send_map(MAP_MAGIC, 0, 5, HDR_LEN, -1);
		send_map(MAP_MAGIC, 5, 0, HDR_LEN, -1);
	endtask

	task automatic test_pixel_edges();
		send_map(MAP_MAGIC, 1, 1, map_bytes(1, 1), 8'h00);
		send_map(MAP_MAGIC, 1, 1, map_bytes(1, 1), 8'hFF);
		send_map(MAP_MAGIC, 3, 2, map_bytes(3, 2), -1);
		// half a sample, a missing pixel, then bytes past a full map
		send_map(MAP_MAGIC, 3, 2, map_bytes(3, 2) - 1, -1);
		send_map(MAP_MAGIC, 3, 2, map_bytes(3, 2) - 2, -1);
		send_map(MAP_MAGIC, 3, 2, map_bytes(3, 2) + 3, -1);
		send_map(MAP_MAGIC, 0, 4, HDR_LEN + 3, -1);
	endtask

	task automatic test_bad_magic();
		send_map(~MAP_MAGIC, 2, 3, map_bytes(2, 3), -1);
		// first error wins over an oversized width
		send_map(MAP_MAGIC ^ (64'd1 << 63), 5000, 2, HDR_LEN + 6, -1);
	endtask

	task automatic test_dim_limit();
		send_map(MAP_MAGIC, 64'(MAX_SIDE + 1), 2, HDR_LEN + 4, -1);
		send_map(MAP_MAGIC, 2, '1, HDR_LEN + 6, -1);
		send_map(MAP_MAGIC, 64'h1_0000_0003, 1, HDR_LEN + 2, -1);
		send_map(MAP_MAGIC, 64'(MAX_SIDE), 0, HDR_LEN, -1);
		// largest accepted width and height, cut short after a few pixels
		send_map(MAP_MAGIC, 64'(MAX_SIDE), 1, HDR_LEN + 8, -1);
		send_map(MAP_MAGIC, 1, 64'(MAX_SIDE), HDR_LEN + 8, -1);
	endtask

	task automatic test_random_maps(input int n);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n)
			random_map();
	endtask

	task automatic test_back_to_back(input int n);
		idle_on = 1'b0;
		test_random_maps(n);
		idle_on = 1'b1;
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Stall the result stream at random, except in the back-to-back test
	always @(negedge clk)
		m_axis_tready <= idle_on ? ($urandom_range(99) >= 15) : 1'b1;

	// Compare each accepted result with the oldest one owed
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual tdata=%h tuser=%b tlast=%b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("result_kind", 16'(want.kind), 16'(m_axis_tuser));
				check_field("depth_value", want.depth, m_axis_tdata[15:0]);
				check_field("pixel_row", 16'(want.row), 16'(m_axis_tdata[27:16]));
				check_field("pixel_column", 16'(want.col), 16'(m_axis_tdata[39:28]));
				check_field("status", 16'(want.status), 16'(m_axis_tdata[42:40]));
				check_field("last", 16'(want.last), 16'(m_axis_tlast));
				check_field("tdata padding", 16'd0, 16'(m_axis_tdata[47:43]));
				if (want.kind == KIND_STATUS)
					status_seen[want.status]++;
				else
					pixels_seen++;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_header_edges();
		test_pixel_edges();
		test_bad_magic();
		test_dim_limit();
		test_random_maps(600);
		test_back_to_back(250);
		// drop valid and drain
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d payloads in %0d bytes; checked %0d pixels", maps_sent, bytes_sent,
			pixels_seen);
		$display("Final status: ok %0d, short %0d, magic %0d, mismatch %0d, too large %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (fail_count == 0)
			$display("depth_map_stream_decoder regression: pass");
		else
			$display("depth_map_stream_decoder regression: fail");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("depth_map_stream_decoder regression: fail");
		$finish;
	end

endmodule
